### rtl/jph_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the joystick position hysteresis block.
package jph_pkg;

    localparam int SAMPLE_W  = 10;
    localparam int LEVEL_W   = 7;
    localparam int POS_W     = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 10;

    localparam logic [CFG_IDX_W-1:0] REG_ACTUATION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DISCONN   = 2'd2;

    localparam logic [LEVEL_W-1:0]  ACTUATION_RESET = 7'd50;
    localparam logic [LEVEL_W-1:0]  RELEASE_RESET   = 7'd30;
    localparam logic [SAMPLE_W-1:0] DISCONN_RESET   = 10'd10;

    localparam int QUOT_W    = 18;
    localparam int DIV_STEPS = QUOT_W / 2;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [QUOT_W-1:0] DIVIDEND  = 18'd96282;
    localparam logic [QUOT_W-1:0] OFFSET    = 18'd194;
    localparam logic [QUOT_W-1:0] HIGH_QUOT = 18'd293;
    localparam logic [QUOT_W-1:0] LOW_QUOT  = 18'd95;
    localparam logic signed [POS_W-1:0] POS_MAX = 8'sd99;
    localparam logic signed [POS_W-1:0] POS_MIN = -8'sd99;

    typedef struct packed {
        logic [SAMPLE_W-1:0] x_sample;
        logic [SAMPLE_W-1:0] y_sample;
        logic                button_pressed;
    } in_word_t;

    typedef struct packed {
        logic                    disconnected;
        logic                    left_on;
        logic                    right_on;
        logic                    up_on;
        logic                    down_on;
        logic                    trigger_on;
        logic signed [POS_W-1:0] x_position;
        logic signed [POS_W-1:0] y_position;
    } out_word_t;

    typedef struct packed {
        logic capture;
        logic div_init;
        logic div_sel_y;
        logic div_step;
        logic store_x;
        logic store_y;
        logic update_flags;
        logic clear_flags;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic disc;
        logic out_free;
    } dp_status_t;

endpackage

### rtl/jph_ctrl.sv
`timescale 1ns / 1ps
// Sequencer that steps one poll through check, two divisions, update and output.
module jph_ctrl
    import jph_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  dp_status_t status,
    output logic       idle,
    output dp_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV_X,
        ST_X_DONE,
        ST_DIV_Y,
        ST_Y_DONE,
        ST_UPDATE,
        ST_EMIT
    } state_t;

    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_STEPS - 1);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.disc)
                begin
                    cmd.clear_flags = 1'b1;
                    state_next      = ST_EMIT;
                end
                else
                begin
                    cmd.div_init = 1'b1;
                    cnt_next     = '0;
                    state_next   = ST_DIV_X;
                end
            end
            ST_DIV_X:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    state_next = ST_X_DONE;
                end
            end
            ST_X_DONE:
            begin
                cmd.store_x   = 1'b1;
                cmd.div_init  = 1'b1;
                cmd.div_sel_y = 1'b1;
                cnt_next      = '0;
                state_next    = ST_DIV_Y;
            end
            ST_DIV_Y:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    state_next = ST_Y_DONE;
                end
            end
            ST_Y_DONE:
            begin
                cmd.store_y = 1'b1;
                state_next  = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.update_flags = 1'b1;
                state_next       = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign idle = (state_reg == ST_IDLE);

endmodule

### rtl/jph_datapath.sv
`timescale 1ns / 1ps
// Level registers, shared two-bit-per-cycle divider, hysteresis flags and output register.
module jph_datapath
    import jph_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  dp_cmd_t              cmd,
    output dp_status_t           status,
    input  in_word_t             sample_word,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    output logic                 result_valid,
    input  logic                 result_stall,
    output out_word_t            result_word
);

    logic [LEVEL_W-1:0]  act_reg, rel_reg;
    logic [SAMPLE_W-1:0] disc_lvl_reg;

    logic [SAMPLE_W-1:0] xs_reg, ys_reg;
    logic                btn_reg, disc_reg;

    logic [SAMPLE_W-1:0] rem_reg, rem_next;
    logic [QUOT_W-1:0]   quot_reg, quot_next;
    logic [SAMPLE_W-1:0] dvs_reg, dvs_next;

    logic signed [POS_W-1:0] held_x_reg, held_y_reg;
    logic [3:0]              flags_reg, flags_next;

    logic      out_valid_reg;
    out_word_t out_word_reg, out_word_next;

    logic [SAMPLE_W:0]   r1, r2;
    logic [SAMPLE_W-1:0] rem1, rem2;
    logic                b1, b2;
    logic [SAMPLE_W-1:0] dvs_sel;
    logic signed [POS_W-1:0] scaled;

    logic signed [POS_W:0] px, py, pa, pr;

    function automatic logic signed [POS_W-1:0] scale_quot(input logic [QUOT_W-1:0] q);
        logic [QUOT_W-1:0] diff;
        diff = q - OFFSET;
        if (q > HIGH_QUOT)
        begin
            return POS_MAX;
        end
        else if (q < LOW_QUOT)
        begin
            return POS_MIN;
        end
        return $signed(diff[POS_W-1:0]);
    endfunction

    function automatic logic [3:0] axis_update(
        input logic [3:0]            f,
        input logic signed [POS_W:0] p,
        input logic signed [POS_W:0] a,
        input logic signed [POS_W:0] r,
        input logic [1:0]            pos_bit,
        input logic [1:0]            neg_bit
    );
        logic [3:0] g;
        g = f;
        if (p < -a)
        begin
            g[neg_bit] = 1'b1;
        end
        if (p > -r)
        begin
            g[neg_bit] = 1'b0;
        end
        if (p > a)
        begin
            g[pos_bit] = 1'b1;
        end
        if (p < r)
        begin
            g[pos_bit] = 1'b0;
        end
        return g;
    endfunction

    always_comb
    begin
        r1   = {rem_reg, quot_reg[QUOT_W-1]};
        b1   = (r1 >= {1'b0, dvs_reg});
        rem1 = b1 ? SAMPLE_W'(r1 - {1'b0, dvs_reg}) : r1[SAMPLE_W-1:0];
        r2   = {rem1, quot_reg[QUOT_W-2]};
        b2   = (r2 >= {1'b0, dvs_reg});
        rem2 = b2 ? SAMPLE_W'(r2 - {1'b0, dvs_reg}) : r2[SAMPLE_W-1:0];
    end

    assign dvs_sel = cmd.div_sel_y ? ys_reg : xs_reg;
    assign scaled  = scale_quot(quot_reg);

    always_comb
    begin
        rem_next  = rem_reg;
        quot_next = quot_reg;
        dvs_next  = dvs_reg;
        if (cmd.div_init)
        begin
            rem_next  = '0;
            quot_next = DIVIDEND;
            dvs_next  = (dvs_sel == '0) ? SAMPLE_W'(1) : dvs_sel;
        end
        else if (cmd.div_step)
        begin
            rem_next  = rem2;
            quot_next = {quot_reg[QUOT_W-3:0], b1, b2};
        end
    end

    assign px = {held_x_reg[POS_W-1], held_x_reg};
    assign py = {held_y_reg[POS_W-1], held_y_reg};
    assign pa = {2'b00, act_reg};
    assign pr = {2'b00, rel_reg};

    always_comb
    begin
        flags_next = flags_reg;
        if (cmd.clear_flags)
        begin
            flags_next = '0;
        end
        else if (cmd.update_flags)
        begin
            flags_next = axis_update(flags_reg, px, pa, pr, 2'd1, 2'd0);
            flags_next = axis_update(flags_next, py, pa, pr, 2'd2, 2'd3);
        end
    end

    always_comb
    begin
        out_word_next.disconnected = disc_reg;
        out_word_next.left_on      = flags_reg[0];
        out_word_next.right_on     = flags_reg[1];
        out_word_next.up_on        = flags_reg[2];
        out_word_next.down_on      = flags_reg[3];
        out_word_next.trigger_on   = btn_reg & ~disc_reg;
        out_word_next.x_position   = held_x_reg;
        out_word_next.y_position   = held_y_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg      <= ACTUATION_RESET;
            rel_reg      <= RELEASE_RESET;
            disc_lvl_reg <= DISCONN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ACTUATION: act_reg      <= cfg_data[LEVEL_W-1:0];
                REG_RELEASE:   rel_reg      <= cfg_data[LEVEL_W-1:0];
                REG_DISCONN:   disc_lvl_reg <= cfg_data[SAMPLE_W-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg     <= '0;
            held_x_reg    <= '0;
            held_y_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            flags_reg <= flags_next;
            if (cmd.store_x)
            begin
                held_x_reg <= -scaled;
            end
            if (cmd.store_y)
            begin
                held_y_reg <= scaled;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        dvs_reg  <= dvs_next;
        if (cmd.capture)
        begin
            xs_reg   <= sample_word.x_sample;
            ys_reg   <= sample_word.y_sample;
            btn_reg  <= sample_word.button_pressed;
            disc_reg <= (sample_word.x_sample < disc_lvl_reg) &&
                        (sample_word.y_sample < disc_lvl_reg);
        end
        if (cmd.load_out)
        begin
            out_word_reg <= out_word_next;
        end
    end

    assign status.disc     = disc_reg;
    assign status.out_free = !out_valid_reg || !result_stall;
    assign result_valid    = out_valid_reg;
    assign result_word     = out_word_reg;

endmodule

### rtl/joystick_position_hysteresis.sv
`timescale 1ns / 1ps
// Top level of the joystick position hysteresis block.
// One poll is taken at a time. A connected poll passes these steps before the next poll
// can be accepted: a disconnect check, two divisions of 96282 by the samples on one shared
// divider that retires two quotient bits per cycle, position stores, the flag update and
// the load of the output register. A disconnected poll clears the flags, then the output
// is loaded. A finished word waits in the output register while the next poll is accepted;
// the block holds a finished word in the sequencer only while the output register is still
// full. Configuration writes are taken every cycle; cfg_ready is always high.
module joystick_position_hysteresis
    import jph_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sample_valid,
    output logic                 sample_stall,
    input  in_word_t             sample_word,
    output logic                 result_valid,
    input  logic                 result_stall,
    output out_word_t            result_word,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;
    logic       idle;
    logic       accept;

    assign sample_stall = !idle;
    assign accept       = sample_valid && idle;
    assign cfg_ready    = 1'b1;

    jph_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (accept),
        .status (status),
        .idle   (idle),
        .cmd    (cmd)
    );

    jph_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .sample_word  (sample_word),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_word  (result_word)
    );

    a_disc_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_word.disconnected |->
            !(result_word.left_on || result_word.right_on || result_word.up_on ||
              result_word.down_on || result_word.trigger_on))
        else $error("disconnected word carries active flags");

    a_lr_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(result_word.left_on && result_word.right_on) &&
                         !(result_word.up_on && result_word.down_on))
        else $error("opposite direction flags both on");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result_word.x_position >= POS_MIN &&
                         result_word.x_position <= POS_MAX &&
                         result_word.y_position >= POS_MIN &&
                         result_word.y_position <= POS_MAX)
        else $error("position out of range");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && !sample_stall |=> sample_stall)
        else $error("poll accepted while previous poll in flight");

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the joystick position hysteresis block.
module tb_top;
    import jph_pkg::*;

    localparam int SCALE_NUM      = 96282;
    localparam int SCALE_OFS      = 194;
    localparam int POS_LIMIT      = 99;
    localparam int ACT_DEFAULT    = 50;
    localparam int REL_DEFAULT    = 30;
    localparam int DISC_DEFAULT   = 10;
    localparam int NUM_PHASES     = 12;
    localparam int PHASE_POLLS    = 96;
    localparam int LONG_HOLD      = 200;
    localparam int END_PAUSE      = 40;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int NUM_ROWS       = 23;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef enum {DRAW_FULL, DRAW_SPAN, DRAW_WALK} draw_t;

    typedef struct packed {
        in_word_t  stim;
        logic      typed;
        out_word_t want;
    } poll_row_t;

    localparam poll_row_t DIRECTED_ROWS [0:NUM_ROWS-1] = '{
        '{'{10'd496, 10'd496, 1'b0}, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'sd0, 8'sd0}},
        '{'{10'd0, 10'd0, 1'b1}, 1'b1, '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'sd0, 8'sd0}},
        '{'{10'd1023, 10'd0, 1'b1}, 1'b1,
          '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 8'sd99, 8'sd99}},
        '{'{10'd0, 10'd1023, 1'b0}, 1'b1,
          '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, -8'sd99, -8'sd99}},
        '{'{10'd9, 10'd9, 1'b1}, 1'b1,
          '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, -8'sd99, -8'sd99}},
        '{'{10'd10, 10'd9, 1'b0}, 1'b1,
          '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, -8'sd99, 8'sd99}},
        '{'{10'd9, 10'd10, 1'b1}, 1'b0, '0},
        '{'{10'd390, 10'd390, 1'b1}, 1'b0, '0},
        '{'{10'd400, 10'd400, 1'b0}, 1'b0, '0},
        '{'{10'd600, 10'd600, 1'b1}, 1'b0, '0},
        '{'{10'd700, 10'd700, 1'b0}, 1'b0, '0},
        '{'{10'd520, 10'd330, 1'b1}, 1'b0, '0},
        '{'{10'd330, 10'd520, 1'b0}, 1'b0, '0},
        '{'{10'd1, 10'd1023, 1'b1}, 1'b0, '0},
        '{'{10'd0, 10'd500, 1'b1}, 1'b0, '0},
        '{'{10'd500, 10'd0, 1'b0}, 1'b0, '0},
        '{'{10'd1023, 10'd1023, 1'b1}, 1'b0, '0},
        '{'{10'd682, 10'd341, 1'b0}, 1'b0, '0},
        '{'{10'd341, 10'd682, 1'b1}, 1'b0, '0},
        '{'{10'd497, 10'd495, 1'b0}, 1'b0, '0},
        '{'{10'd394, 10'd392, 1'b1}, 1'b0, '0},
        '{'{10'd429, 10'd431, 1'b0}, 1'b0, '0},
        '{'{10'd5, 10'd1000, 1'b1}, 1'b0, '0}
    };

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 sample_valid = 1'b0;
    logic                 sample_stall;
    in_word_t             sample_word  = '0;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    out_word_t            result_word;
    logic                 cfg_valid    = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index    = '0;
    logic [CFG_DAT_W-1:0] cfg_data     = '0;

    logic [LEVEL_W-1:0]      act_level;
    logic [LEVEL_W-1:0]      rel_level;
    logic [SAMPLE_W-1:0]     disc_level;
    logic                    left_q;
    logic                    right_q;
    logic                    up_q;
    logic                    down_q;
    logic signed [POS_W-1:0] held_x;
    logic signed [POS_W-1:0] held_y;

    out_word_t due_results[$];
    poll_row_t typed_rows[$];
    int        mismatches  = 0;
    int        quiet_cycles = 0;
    bit        long_hold   = 1'b0;

    joystick_position_hysteresis i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_word  (sample_word),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_word  (result_word),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #6 clk = ~clk;

    function automatic int axis_position(logic [SAMPLE_W-1:0] s);
        int v;
        v = SCALE_NUM / ((s == '0) ? 1 : int'(s)) - SCALE_OFS;
        if (v < -POS_LIMIT)
        begin
            v = -POS_LIMIT;
        end
        if (v > POS_LIMIT)
        begin
            v = POS_LIMIT;
        end
        return v;
    endfunction

    function automatic logic hysteresis(logic on_q, logic set_it, logic clear_it);
        return clear_it ? 1'b0 : (set_it ? 1'b1 : on_q);
    endfunction

    function automatic out_word_t predict_poll(in_word_t w);
        out_word_t r;
        int px;
        int py;
        int a;
        int rl;
        r  = '0;
        a  = int'(act_level);
        rl = int'(rel_level);
        if (w.x_sample < disc_level && w.y_sample < disc_level)
        begin
            r.disconnected = 1'b1;
            left_q  = 1'b0;
            right_q = 1'b0;
            up_q    = 1'b0;
            down_q  = 1'b0;
        end
        else
        begin
            px = -axis_position(w.x_sample);
            py = axis_position(w.y_sample);
            held_x  = px[POS_W-1:0];
            held_y  = py[POS_W-1:0];
            left_q  = hysteresis(left_q, px < -a, px > -rl);
            right_q = hysteresis(right_q, px > a, px < rl);
            up_q    = hysteresis(up_q, py > a, py < rl);
            down_q  = hysteresis(down_q, py < -a, py > -rl);
            r.trigger_on = w.button_pressed;
        end
        r.left_on    = left_q;
        r.right_on   = right_q;
        r.up_on      = up_q;
        r.down_on    = down_q;
        r.x_position = held_x;
        r.y_position = held_y;
        return r;
    endfunction

    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
        begin
            return 0;
        end
        if (r < 85)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 97)
        begin
            return $urandom_range(4, 15);
        end
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [SAMPLE_W-1:0] next_sample(logic [SAMPLE_W-1:0] prev, draw_t mode);
        int v;
        case (mode)
            DRAW_FULL: v = $urandom_range(0, 1023);
            DRAW_SPAN: v = $urandom_range(320, 1023);
            default:
            begin
                v = int'(prev) + int'($urandom_range(0, 60)) - 30;
                if (v < 0)
                begin
                    v = 0;
                end
                if (v > 1023)
                begin
                    v = 1023;
                end
            end
        endcase
        return v[SAMPLE_W-1:0];
    endfunction

    task automatic report(string msg);
        $display("%0t ns: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_word(out_word_t got, out_word_t want);
        if (got.disconnected !== want.disconnected)
            report($sformatf("disconnected got %b want %b", got.disconnected, want.disconnected));
        if (got.left_on !== want.left_on)
            report($sformatf("left_on got %b want %b", got.left_on, want.left_on));
        if (got.right_on !== want.right_on)
            report($sformatf("right_on got %b want %b", got.right_on, want.right_on));
        if (got.up_on !== want.up_on)
            report($sformatf("up_on got %b want %b", got.up_on, want.up_on));
        if (got.down_on !== want.down_on)
            report($sformatf("down_on got %b want %b", got.down_on, want.down_on));
        if (got.trigger_on !== want.trigger_on)
            report($sformatf("trigger_on got %b want %b", got.trigger_on, want.trigger_on));
        if (got.x_position !== want.x_position)
            report($sformatf("x_position got %0d want %0d", got.x_position, want.x_position));
        if (got.y_position !== want.y_position)
            report($sformatf("y_position got %0d want %0d", got.y_position, want.y_position));
    endtask

    always @(posedge clk)
    begin : tracker
        out_word_t want;
        out_word_t predicted;
        poll_row_t row;
        if (!rst_n)
        begin
            act_level  = LEVEL_W'(ACT_DEFAULT);
            rel_level  = LEVEL_W'(REL_DEFAULT);
            disc_level = SAMPLE_W'(DISC_DEFAULT);
            left_q     = 1'b0;
            right_q    = 1'b0;
            up_q       = 1'b0;
            down_q     = 1'b0;
            held_x     = '0;
            held_y     = '0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (due_results.size() == 0)
                begin
                    report("result word with none expected");
                end
                else
                begin
                    want = due_results.pop_front();
                    check_word(result_word, want);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_ACTUATION: act_level  = cfg_data[LEVEL_W-1:0];
                    REG_RELEASE:   rel_level  = cfg_data[LEVEL_W-1:0];
                    REG_DISCONN:   disc_level = cfg_data[SAMPLE_W-1:0];
                    default: ;
                endcase
            end
            if (sample_valid && !sample_stall)
            begin
                predicted = predict_poll(sample_word);
                if (typed_rows.size() != 0)
                begin
                    row = typed_rows.pop_front();
                    due_results.push_back(row.typed ? row.want : predicted);
                end
                else
                begin
                    due_results.push_back(predicted);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (sample_valid && !sample_stall) || (result_valid && !result_stall)
            || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("** joystick_position_hysteresis: FAILED **");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin : result_side
        int pick;
        int span;
        @(posedge clk);
        forever
        begin
            pick = $urandom_range(0, 99);
            if (long_hold)
            begin
                result_stall <= 1'b1;
                span = LONG_HOLD;
                long_hold = 1'b0;
            end
            else if (pick < 50)
            begin
                result_stall <= 1'b0;
                span = $urandom_range(1, 8);
            end
            else if (pick < 85)
            begin
                result_stall <= 1'b1;
                span = $urandom_range(1, 3);
            end
            else if (pick < 95)
            begin
                result_stall <= 1'b1;
                span = $urandom_range(5, 40);
            end
            else
            begin
                result_stall <= 1'b0;
                span = $urandom_range(30, 100);
            end
            repeat (span) @(posedge clk);
        end
    end

    task automatic send_poll(in_word_t w);
        sample_valid <= 1'b1;
        sample_word  <= w;
        do
            @(posedge clk);
        while (sample_stall);
    endtask

    task automatic pause_sender(int n);
        if (n > 0)
        begin
            sample_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (due_results.size() != 0);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    initial
    begin : stimulus
        in_word_t             word;
        logic [CFG_DAT_W-1:0] act_data;
        logic [CFG_DAT_W-1:0] rel_data;
        logic [CFG_DAT_W-1:0] disc_data;
        draw_t                mode;
        int                   pick;
        bit                   calm;
        word = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_ROWS; i++)
        begin
            typed_rows.push_back(DIRECTED_ROWS[i]);
            send_poll(DIRECTED_ROWS[i].stim);
            pause_sender(pick_idle());
        end

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            sample_valid <= 1'b0;
            wait_drained();
            if (phase > 0)
            begin
                case (phase)
                    1:
                    begin
                        act_data = 10'd0; rel_data = 10'd0; disc_data = 10'd0;
                    end
                    2:
                    begin
                        act_data = 10'd99; rel_data = 10'd99; disc_data = 10'd1023;
                    end
                    3:
                    begin
                        act_data = 10'h38A; rel_data = 10'd40; disc_data = 10'd200;
                    end
                    4:
                    begin
                        act_data = 10'h3FF; rel_data = 10'h3FF; disc_data = 10'd512;
                    end
                    5:
                    begin
                        act_data = 10'd60; rel_data = 10'd20; disc_data = 10'd10;
                    end
                    default:
                    begin
                        act_data  = CFG_DAT_W'($urandom_range(0, 1023));
                        rel_data  = CFG_DAT_W'($urandom_range(0, 1023));
                        disc_data = CFG_DAT_W'($urandom_range(0, 600));
                    end
                endcase
                write_reg(REG_ACTUATION, act_data);
                write_reg(REG_RELEASE, rel_data);
                if (phase == 5)
                begin
                    write_reg(REG_UNUSED, 10'h155);
                end
                write_reg(REG_DISCONN, disc_data);
                cfg_valid <= 1'b0;
            end
            calm = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < PHASE_POLLS; k++)
            begin
                if (k == 20 && (phase == 3 || phase == 8))
                begin
                    long_hold = 1'b1;
                end
                if (k == 50 && phase == 6)
                begin
                    sample_valid <= 1'b0;
                    wait_drained();
                end
                pick = $urandom_range(0, 99);
                if (pick < 10 && disc_level != '0)
                begin
                    word.x_sample = SAMPLE_W'($urandom_range(0, disc_level - 1));
                    word.y_sample = SAMPLE_W'($urandom_range(0, disc_level - 1));
                end
                else
                begin
                    mode = (pick < 55) ? DRAW_SPAN : ((pick < 85) ? DRAW_WALK : DRAW_FULL);
                    word.x_sample = next_sample(word.x_sample, mode);
                    word.y_sample = next_sample(word.y_sample, mode);
                end
                word.button_pressed = 1'($urandom_range(0, 1));
                send_poll(word);
                pause_sender((calm || long_hold) ? 0 : pick_idle());
            end
        end

        sample_valid <= 1'b0;
        wait_drained();
        repeat (END_PAUSE) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("** joystick_position_hysteresis: PASSED **");
        end
        else
        begin
            $display("** joystick_position_hysteresis: FAILED **");
        end
        $finish;
    end

endmodule

### joystick_position_hysteresis.f
rtl/jph_pkg.sv
rtl/jph_ctrl.sv
rtl/jph_datapath.sv
rtl/joystick_position_hysteresis.sv
bench/tb_top.sv
